// ----- rtl/sia_pkg.sv -----
// Shared types, register indexes and a helper function of the four-axis interpolator.
package sia_pkg;

	localparam int AxisCountDef   = 4;
	localparam int HomeAngleDef   = 90;
	localparam int HomeGripperDef = 0;
	localparam int AngleLimit     = 180;
	localparam int FieldAxes      = 4;
	localparam int AddrW          = 5;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_BASE_MIN  = 3'd0,
		REG_BASE_MAX  = 3'd1,
		REG_SH_MIN    = 3'd2,
		REG_SH_MAX    = 3'd3,
		REG_EL_MIN    = 3'd4,
		REG_EL_MAX    = 3'd5,
		REG_GRIP_MAX  = 3'd6,
		REG_STEP_SIZE = 3'd7
	} reg_idx_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_ACCEPTED = 3'd0,
		ST_THERE    = 3'd1,
		ST_RANGE    = 3'd2,
		ST_STEP     = 3'd3,
		ST_IDLE     = 3'd4,
		ST_BUSY     = 3'd5
	} status_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] target_base;
		logic [7:0] target_shoulder;
		logic [7:0] target_elbow;
		logic [7:0] target_gripper;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] out_base;
		logic [7:0] out_shoulder;
		logic [7:0] out_elbow;
		logic [7:0] out_gripper;
		logic       last_step;
	} rsp_t;

	// Limit an angle to the servo range.
	function automatic logic [7:0] clamp_angle(input logic [7:0] a);
		clamp_angle = (a > 8'(AngleLimit)) ? 8'(AngleLimit) : a;
	endfunction

endpackage

// ----- rtl/sia_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module sia_div import sia_pkg::*; #(
	parameter int DW = 16,
	parameter int VW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] dq_q;
	logic [VW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   rem_sh;
	logic [VW:0]   rem_sub;
	logic          fits;

	// Shift in the next dividend bit and try the subtraction.
	always_comb begin
		rem_sh  = {rem_q, dq_q[DW-1]};
		rem_sub = rem_sh - {1'b0, divisor};
		fits    = rem_sh >= {1'b0, divisor};
	end

	// Control of the iteration count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(DW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_sub[VW-1:0];
				dq_q  <= {dq_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[VW-1:0];
				dq_q  <= {dq_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;
endmodule

// ----- rtl/sia_lane.sv -----
// One axis lane: distance times step number, then divided by the step count.
module sia_lane import sia_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  logic [7:0] start_ang,
	input  logic [7:0] goal_ang,
	input  logic [7:0] k,
	input  logic [7:0] total,
	output logic       done,
	output logic [7:0] pos
);
	logic        up;
	logic [7:0]  span;
	logic [15:0] prod_s1;
	logic        mul_vld_s1;
	logic [15:0] quot;

	assign up   = goal_ang >= start_ang;
	assign span = up ? (goal_ang - start_ang) : (start_ang - goal_ang);

	// Registered product feeds the divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_vld_s1 <= 1'b0;
		end else begin
			mul_vld_s1 <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			prod_s1 <= 16'(span) * 16'(k);
		end
	end

	sia_div #(.DW(16), .VW(8)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mul_vld_s1),
		.dividend (prod_s1),
		.divisor  (total),
		.done     (done),
		.quotient (quot)
	);

	// The quotient never exceeds the distance, so it fits in eight bits.
	assign pos = up ? (start_ang + quot[7:0]) : (start_ang - quot[7:0]);
endmodule

// ----- rtl/four_axis_sync_interpolator.sv -----
// Top level of the four-axis synchronized linear interpolator.
// One item is processed at a time. A rejected move, a move already at its target, an idle tick
// or a busy move passes from the evaluate state through the output state into the output
// register. An accepted move waits in the count state on the 16-step serial divider that works
// out the step count. A tick of a running move waits in the lane state: one lane per axis
// registers distance times step number and then runs its own 16-step serial divider, all lanes
// in parallel. The sequencer is idle again once the result enters the output register; a result
// that waits on a stalled output register holds the sequencer until the register frees.
module four_axis_sync_interpolator import sia_pkg::*; #(
	parameter int AXIS_COUNT   = AxisCountDef,
	parameter int HOME_ANGLE   = HomeAngleDef,
	parameter int HOME_GRIPPER = HomeGripperDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EVAL = 5'b00010,
		S_CNT  = 5'b00100,
		S_LANE = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t          state_q;
	logic [7:0]      regs_q [8];
	req_t            item_q;
	logic [7:0]      start_q [AXIS_COUNT];
	logic [7:0]      goal_q [AXIS_COUNT];
	logic [7:0]      pos_q [AXIS_COUNT];
	logic [7:0]      idx_q;
	logic [7:0]      total_q;
	logic            moving_q;
	status_t         status_q;
	logic            last_q;
	logic            rsp_valid_q;
	rsp_t            rsp_q;

	logic [7:0]      tgt [AXIS_COUNT];
	logic            ok [AXIS_COUNT];
	logic [7:0]      lane_pos [AXIS_COUNT];
	logic [AXIS_COUNT-1:0] lane_done;
	logic            all_ok;
	logic [7:0]      maxd;
	logic [7:0]      ss_eff;
	logic [7:0]      k;
	logic            lane_go;
	logic            cnt_go;
	logic            cnt_done;
	logic [15:0]     cnt_quot;
	logic            wr_en;
	logic            out_free;
	logic [7:0]      out_ang [FieldAxes];

	// Configuration port.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign prdata = {24'd0, regs_q[paddr[AddrW-1:2]]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[REG_BASE_MIN]  <= 8'd0;
			regs_q[REG_BASE_MAX]  <= 8'(AngleLimit);
			regs_q[REG_SH_MIN]    <= 8'd0;
			regs_q[REG_SH_MAX]    <= 8'(AngleLimit);
			regs_q[REG_EL_MIN]    <= 8'd0;
			regs_q[REG_EL_MAX]    <= 8'(AngleLimit);
			regs_q[REG_GRIP_MAX]  <= 8'(AngleLimit);
			regs_q[REG_STEP_SIZE] <= 8'd1;
		end else if (wr_en) begin
			regs_q[paddr[AddrW-1:2]] <= pwdata[7:0];
		end
	end

	// Per-axis target selection and limit check.
	for (genvar i = 0; i < AXIS_COUNT; i++) begin : g_axis
		always_comb begin
			tgt[i] = (i == 3) ? 8'(HOME_GRIPPER) : 8'(HOME_ANGLE);
			ok[i]  = 1'b1;
			case (i)
				0: begin
					tgt[i] = item_q.target_base;
					ok[i]  = tgt[i] >= regs_q[REG_BASE_MIN] && tgt[i] <= regs_q[REG_BASE_MAX];
				end
				1: begin
					tgt[i] = item_q.target_shoulder;
					ok[i]  = tgt[i] >= regs_q[REG_SH_MIN] && tgt[i] <= regs_q[REG_SH_MAX];
				end
				2: begin
					tgt[i] = item_q.target_elbow;
					ok[i]  = tgt[i] >= regs_q[REG_EL_MIN] && tgt[i] <= regs_q[REG_EL_MAX];
				end
				3: begin
					tgt[i] = item_q.target_gripper;
					ok[i]  = tgt[i] <= regs_q[REG_GRIP_MAX];
				end
				default: begin
					ok[i] = 1'b1;
				end
			endcase
		end

		sia_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.go        (lane_go),
			.start_ang (start_q[i]),
			.goal_ang  (goal_q[i]),
			.k         (k),
			.total     (total_q),
			.done      (lane_done[i]),
			.pos       (lane_pos[i])
		);
	end

	// Merge the lanes: all limits met and the largest distance.
	always_comb begin
		logic [7:0] d;
		all_ok = 1'b1;
		maxd   = '0;
		for (int i = 0; i < AXIS_COUNT; i++) begin
			d = (tgt[i] >= start_q[i]) ? (tgt[i] - start_q[i]) : (start_q[i] - tgt[i]);
			all_ok = all_ok && ok[i];
			if (d > maxd) begin
				maxd = d;
			end
		end
	end

	assign ss_eff  = (regs_q[REG_STEP_SIZE] == 8'd0) ? 8'd1 : regs_q[REG_STEP_SIZE];
	assign k       = idx_q + 8'd1;
	assign lane_go = (state_q == S_EVAL) && item_q.cmd && moving_q;
	assign cnt_go  = (state_q == S_EVAL) && !item_q.cmd && !moving_q && all_ok
	                 && (maxd != 8'd0);

	// Step count is the ceiling of the largest distance over the step size.
	sia_div #(.DW(16), .VW(8)) u_cnt_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cnt_go),
		.dividend (16'(maxd) + 16'(ss_eff) - 16'd1),
		.divisor  (ss_eff),
		.done     (cnt_done),
		.quotient (cnt_quot)
	);

	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// Sequencer and move state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			total_q  <= '0;
			moving_q <= 1'b0;
			for (int i = 0; i < AXIS_COUNT; i++) begin
				start_q[i] <= (i == 3) ? 8'(HOME_GRIPPER) : 8'(HOME_ANGLE);
				goal_q[i]  <= (i == 3) ? 8'(HOME_GRIPPER) : 8'(HOME_ANGLE);
				pos_q[i]   <= (i == 3) ? 8'(HOME_GRIPPER) : 8'(HOME_ANGLE);
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (cnt_go) begin
						for (int i = 0; i < AXIS_COUNT; i++) begin
							goal_q[i] <= tgt[i];
						end
						state_q <= S_CNT;
					end else if (lane_go) begin
						state_q <= S_LANE;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_CNT: begin
					if (cnt_done) begin
						total_q  <= cnt_quot[7:0];
						idx_q    <= '0;
						moving_q <= 1'b1;
						state_q  <= S_OUT;
					end
				end
				S_LANE: begin
					if (&lane_done) begin
						for (int i = 0; i < AXIS_COUNT; i++) begin
							pos_q[i] <= lane_pos[i];
						end
						if (k == total_q) begin
							for (int i = 0; i < AXIS_COUNT; i++) begin
								start_q[i] <= goal_q[i];
							end
							idx_q    <= '0;
							total_q  <= '0;
							moving_q <= 1'b0;
						end else begin
							idx_q <= k;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture the item and the status of its result.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			item_q <= req;
		end
		case (state_q)
			S_EVAL: begin
				last_q <= 1'b0;
				if (item_q.cmd) begin
					status_q <= moving_q ? ST_STEP : ST_IDLE;
				end else if (moving_q) begin
					status_q <= ST_BUSY;
				end else if (!all_ok) begin
					status_q <= ST_RANGE;
				end else if (maxd == 8'd0) begin
					status_q <= ST_THERE;
				end else begin
					status_q <= ST_ACCEPTED;
				end
			end
			S_LANE: begin
				if (&lane_done) begin
					last_q <= (k == total_q);
				end
			end
			default: begin
			end
		endcase
	end

	// Output angles, zero for axes the block does not have.
	always_comb begin
		for (int i = 0; i < FieldAxes; i++) begin
			out_ang[i] = '0;
			if (i < AXIS_COUNT) begin
				out_ang[i] = clamp_angle(pos_q[i]);
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			rsp_q.status       <= status_q;
			rsp_q.out_base     <= out_ang[0];
			rsp_q.out_shoulder <= out_ang[1];
			rsp_q.out_elbow    <= out_ang[2];
			rsp_q.out_gripper  <= out_ang[3];
			rsp_q.last_step    <= last_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
endmodule
